// ----- hw/rtl/cgms_pkg.sv -----
// ----------------------------------------------------------------------------
// cgms_pkg
// Shared constants, stream field layout and types of the genome motif scanner.
// ----------------------------------------------------------------------------
package cgms_pkg;

    // genome store
    localparam int MAX_LENGTH  = 4096;
    localparam int MIN_LENGTH  = 32;
    localparam int ADDR_W      = $clog2(MAX_LENGTH);
    localparam int LEN_W       = ADDR_W + 1;
    // remainder unit: quotient of a position by a length of at least MIN_LENGTH
    localparam int QUOT_W      = ADDR_W - $clog2(MIN_LENGTH);
    localparam int STEP_W      = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;
    localparam int DIV_W       = LEN_W + QUOT_W;

    // motif geometry
    localparam int PROMOTER_SIZE = 22;
    localparam int TERM_STEM     = 4;
    localparam int TERM_SPAN     = 11;
    localparam int CODON_BITS    = 3;
    localparam int SD_SPACER     = 4;
    localparam int SD_CORE       = 6;
    localparam int CNT_W         = $clog2(PROMOTER_SIZE + 1);

    // register widths
    localparam int PROM_W  = 22;
    localparam int DIFF_W  = 5;
    localparam int SHINE_W = 13;
    localparam int STOPP_W = 3;
    localparam int CFG_W   = 22;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMOTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHINE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 3'd4;

    // commands
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLIP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // result field widths
    localparam int DIST_W  = 5;
    localparam int STEM_W  = 3;
    localparam int CODON_W = 3;

    // stream layout
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_USED_W  = DIST_W + STEM_W + 2 + CODON_W;

    // memory request
    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              wdata;
    } t_mem_req;

    // remainder unit response
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] rem;
    } t_mod_rsp;

endpackage

// ----- hw/rtl/cgms_mod.sv -----
// ----------------------------------------------------------------------------
// cgms_mod
// Restoring remainder unit: position modulo genome length, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module cgms_mod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [cgms_pkg::ADDR_W-1:0] i_pos,
    input  logic [cgms_pkg::LEN_W-1:0]  i_len,
    output cgms_pkg::t_mod_rsp     o_rsp
);
    import cgms_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_rem;
    logic [LEN_W-1:0]  r_len;
    logic [DIV_W-1:0]  w_sub;
    logic [DIV_W-1:0]  w_rem_ext;

    assign w_sub     = DIV_W'(r_len) << r_step;
    assign w_rem_ext = DIV_W'(r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_pos;
            r_len  <= i_len;
            r_step <= STEP_W'(QUOT_W - 1);
        end else if (r_busy) begin
            if (w_rem_ext >= w_sub) begin
                r_rem <= ADDR_W'(w_rem_ext - w_sub);
            end
            r_step <= r_step - 1'b1;
        end
    end

    // done follows the last step; the remainder is valid in the same cycle as done
    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_step == '0 && !i_start;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- hw/rtl/cgms_bitmem.sv -----
// ----------------------------------------------------------------------------
// cgms_bitmem
// Genome bit store: one port, registered read data.
// ----------------------------------------------------------------------------
module cgms_bitmem (
    input  logic               i_clk,
    input  cgms_pkg::t_mem_req i_req,
    output logic               o_rdata
);
    import cgms_pkg::*;

    logic r_mem [MAX_LENGTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/circular_genome_motif_scanner.sv -----
// ----------------------------------------------------------------------------
// circular_genome_motif_scanner
// Circular binary genome in a bit memory; write, flip and query requests.
// A query scans the window at the position and reports motif matches.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | tvalid/tready                | tdata: cmd, position, base_value
//  m_axis    | out       | tvalid/tready, output reg    | tdata: distance, stem, sd, stop, codon
//  cfg       | in        | i_cfg_we, no wait            | i_cfg_idx, i_cfg_data
//
//  Sequence: the remainder unit takes QUOT_W (7) steps plus a done flag before
//  the wrapped address is ready. A write then stores the bit; a flip reads,
//  then writes back inverted. A query issues PROMOTER_SIZE (22) reads, one
//  memory read per window bit on the single memory port, then loads the result.
//  Reset clears control only; genome memory contents are undefined until written.
//  A finished query waits in the output register; a stalled result holds
//  the sequencer before the next result is loaded, while writes still proceed.
// ----------------------------------------------------------------------------
module circular_genome_motif_scanner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [cgms_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cgms_pkg::CFG_W-1:0]           i_cfg_data,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] cmd, [13:2] position, [14] base_value, [15] zero
    input  logic [cgms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [4:0] promoter_distance, [7:5] terminator_stem, [8] shine_start,
    // [9] stop_found, [12:10] codon_value, [15:13] zero
    output logic [cgms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import cgms_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_FLIP = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // ---------------- configuration ----------------
    logic [LEN_W-1:0]   r_len;       // already clamped to [MIN_LENGTH, MAX_LENGTH]
    logic [PROM_W-1:0]  r_prom;
    logic [DIFF_W-1:0]  r_max_diff;
    logic [SHINE_W-1:0] r_shine;
    logic [STOPP_W-1:0] r_stop;
    logic [LEN_W-1:0]   w_len_in;

    assign w_len_in = i_cfg_data[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_W'(MAX_LENGTH);
            r_prom     <= '0;
            r_max_diff <= DIFF_W'(4);
            r_shine    <= '0;
            r_stop     <= STOPP_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LENGTH: begin
                    if (w_len_in < LEN_W'(MIN_LENGTH)) begin
                        r_len <= LEN_W'(MIN_LENGTH);
                    end else if (w_len_in > LEN_W'(MAX_LENGTH)) begin
                        r_len <= LEN_W'(MAX_LENGTH);
                    end else begin
                        r_len <= w_len_in;
                    end
                end
                CFG_PROMOTER: r_prom     <= i_cfg_data[PROM_W-1:0];
                CFG_MAX_DIFF: r_max_diff <= i_cfg_data[DIFF_W-1:0];
                CFG_SHINE:    r_shine    <= i_cfg_data[SHINE_W-1:0];
                CFG_STOP:     r_stop     <= i_cfg_data[STOPP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- request decode ----------------
    logic [CMD_W-1:0]  w_in_cmd;
    logic [ADDR_W-1:0] w_in_pos;
    logic              w_in_base;
    logic              w_in_acc;

    assign w_in_cmd  = s_axis_tdata[CMD_W-1:0];
    assign w_in_pos  = s_axis_tdata[CMD_W +: ADDR_W];
    assign w_in_base = s_axis_tdata[CMD_W + ADDR_W];

    logic [2:0] r_state, n_state;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // unused command code is dropped at the door
    logic w_start;
    assign w_start = w_in_acc && (w_in_cmd == CMD_WRITE || w_in_cmd == CMD_FLIP
                                  || w_in_cmd == CMD_QUERY);

    // ---------------- remainder unit ----------------
    t_mod_rsp w_mod;

    cgms_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_pos   (w_in_pos),
        .i_len   (r_len),
        .o_rsp   (w_mod)
    );

    // ---------------- genome memory ----------------
    t_mem_req w_req;
    logic     w_rdata;

    cgms_bitmem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // ---------------- working registers ----------------
    logic [CMD_W-1:0]         r_cmd;
    logic                     r_base;
    logic [ADDR_W-1:0]        r_addr;     // wrapped base address, for flip write-back
    logic [ADDR_W-1:0]        r_cur;      // next window address to read
    logic [CNT_W-1:0]         r_iss;      // window reads issued
    logic [CNT_W-1:0]         r_rcv;      // window bits received
    logic                     r_rd_vld;   // memory read data valid this cycle
    logic [PROMOTER_SIZE-1:0] r_win;      // bit i = base at offset i once full
    logic [PROM_W-1:0]        r_pat;      // promoter pattern, shifted in step with r_win
    logic [DIST_W-1:0]        r_dist;
    logic                     r_out_vld;
    logic [OUT_TDATA_W-1:0]   r_out_data;

    // next wrapped address: offsets stay below MIN_LENGTH, one compare does it
    logic [ADDR_W-1:0] w_next_cur;
    assign w_next_cur = (LEN_W'(r_cur) + 1'b1 == r_len) ? '0 : r_cur + 1'b1;

    logic w_out_free;
    assign w_out_free = !r_out_vld || m_axis_tready;

    // memory requests; a flip reads then writes the same entry, and the
    // next request is not accepted until that write is done
    always_comb begin
        w_req = '0;
        case (r_state)
            S_MOD: begin
                if (w_mod.done) begin
                    w_req.addr  = w_mod.rem;
                    w_req.wdata = r_base;
                    w_req.we    = (r_cmd == CMD_WRITE);
                    w_req.re    = (r_cmd != CMD_WRITE);
                end
            end
            S_FLIP: begin
                w_req.we    = 1'b1;
                w_req.addr  = r_addr;
                w_req.wdata = ~w_rdata;
            end
            S_SCAN: begin
                w_req.re   = (r_iss < CNT_W'(PROMOTER_SIZE));
                w_req.addr = r_cur;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_start) n_state = S_MOD;
            S_MOD: begin
                if (w_mod.done) begin
                    case (r_cmd)
                        CMD_WRITE: n_state = S_IDLE;
                        CMD_FLIP:  n_state = S_FLIP;
                        default:   n_state = S_SCAN;
                    endcase
                end
            end
            S_FLIP: n_state = S_IDLE;
            S_SCAN: begin
                if (r_rd_vld && r_rcv == CNT_W'(PROMOTER_SIZE - 1)) n_state = S_FIN;
            end
            S_FIN: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_req.re && (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd  <= w_in_cmd;
            r_base <= w_in_base;
        end
        if (r_state == S_MOD && w_mod.done) begin
            r_addr <= w_mod.rem;
            r_cur  <= w_mod.rem;
            r_iss  <= '0;
            r_rcv  <= '0;
            r_dist <= '0;
            r_pat  <= r_prom;
        end
        if (r_state == S_SCAN) begin
            if (w_req.re) begin
                r_iss <= r_iss + 1'b1;
                r_cur <= w_next_cur;
            end
            if (r_rd_vld) begin
                r_win  <= {w_rdata, r_win[PROMOTER_SIZE-1:1]};
                r_pat  <= r_pat >> 1;
                r_dist <= r_dist + DIST_W'(w_rdata ^ r_pat[0]);
                r_rcv  <= r_rcv + 1'b1;
            end
        end
    end

    // ---------------- result evaluation ----------------
    logic [DIFF_W:0]       w_cap;
    logic [DIST_W-1:0]     w_dist;
    logic [STEM_W-1:0]     w_stem;
    logic                  w_sd;
    logic                  w_stop_hit;
    logic [CODON_W-1:0]    w_codon;

    assign w_cap  = (DIFF_W + 1)'(r_max_diff) + 1'b1;
    assign w_dist = ((DIFF_W + 1)'(r_dist) > w_cap) ? w_cap[DIST_W-1:0] : r_dist;

    always_comb begin
        w_stem = STEM_W'(TERM_STEM);
        for (int i = 0; i < TERM_STEM; i++) begin
            if (r_win[i] == r_win[TERM_SPAN-1-i]) w_stem = '0;
        end
        w_sd = 1'b1;
        for (int i = 0; i < SD_CORE + CODON_BITS; i++) begin
            if (i < SD_CORE) begin
                if (r_win[i] != r_shine[i]) w_sd = 1'b0;
            end else begin
                if (r_win[i + SD_SPACER] != r_shine[i + SD_SPACER]) w_sd = 1'b0;
            end
        end
        w_stop_hit = 1'b1;
        w_codon    = '0;
        for (int i = 0; i < CODON_BITS; i++) begin
            if (r_win[i] != r_stop[i]) w_stop_hit = 1'b0;
            w_codon = {w_codon[CODON_W-2:0], r_win[i]};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_FIN && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            r_out_data <= {(OUT_TDATA_W - OUT_USED_W)'(0), w_codon, w_stop_hit, w_sd,
                           w_stem, w_dist};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hw/rtl/cgms_checker.sv -----
// ----------------------------------------------------------------------------
// cgms_checker
// Port-level checks of the genome motif scanner, bound to the top level.
// ----------------------------------------------------------------------------
module cgms_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [cgms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cgms_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cgms_pkg::*;

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // any real command keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tdata[CMD_W-1:0] == CMD_WRITE || s_axis_tdata[CMD_W-1:0] == CMD_FLIP
            || s_axis_tdata[CMD_W-1:0] == CMD_QUERY) |=> !s_axis_tready)
        else $error("request taken while busy");

    // promoter distance never exceeds the window size
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DIST_W-1:0] <= DIST_W'(PROMOTER_SIZE))
        else $error("promoter distance out of range");

    // stem is all or nothing
    a_stem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DIST_W +: STEM_W] == '0
                       || m_axis_tdata[DIST_W +: STEM_W] == STEM_W'(TERM_STEM))
        else $error("bad terminator stem");

endmodule

bind circular_genome_motif_scanner cgms_checker u_cgms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/circular_genome_motif_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// circular_genome_motif_scanner_tb
// Self-checking bench for the genome motif scanner. A directed table covers
// reset state, wrap-around, extremes of the registers and the ignored command.
// Random phases follow, one register setting per phase. Each phase is mostly
// motif windows written next to the queried position, then flips and queries.
// Every query result is checked field by field against an in-bench model of
// the genome store and the motif rules. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module circular_genome_motif_scanner_tb;

    import cgms_pkg::*;

    // bench knobs
    localparam int IDLE_PCT       = 18;      // percent of idle cycles per side
    localparam int SETTLE_CYCLES  = 64;      // past the longest request, a query
    localparam int CYCLE_LIMIT    = 400000;  // watchdog
    localparam int N_PHASES       = 8;
    localparam int PHASE_REQUESTS = 215;
    localparam int CALM_PHASE     = 2;       // no idling on either side here
    localparam int MAX_REPORTS    = 40;
    // widest offset read by a query is PROMOTER_SIZE-1; the others are shorter
    localparam int WINDOW         = PROMOTER_SIZE;

    // the one command code the package leaves unnamed; the block ignores it
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // result word as it sits in m_axis_tdata, lowest field last
    typedef struct packed {
        logic [OUT_TDATA_W-OUT_USED_W-1:0] pad;
        logic [CODON_W-1:0]                codon;
        logic                              stop;
        logic                              shine;
        logic [STEM_W-1:0]                 stem;
        logic [DIST_W-1:0]                 prom_dist;
    } t_scan_result;

    typedef enum logic {ROW_REQUEST, ROW_REGISTER} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CMD_W-1:0]       cmd;
        logic [ADDR_W-1:0]      pos;
        logic                   bv;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       val;
        bit                     typed;   // want holds a hand-written result
        t_scan_result           want;
    } t_plan_row;

    // DUT inputs, all known from time zero
    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_W-1:0]        i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    m_axis_tready = 1'b1;
    // DUT outputs
    logic                    s_axis_tready;
    logic                    m_axis_tvalid;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    circular_genome_motif_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: registers at their reset values, genome store,
    // and which store entries have been written since power-up.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]    cfg_length   = LEN_W'(MAX_LENGTH);
    logic [PROM_W-1:0]   cfg_promoter = '0;
    logic [DIFF_W-1:0]   cfg_max_diff = DIFF_W'(4);
    logic [SHINE_W-1:0]  cfg_shine    = '0;
    logic [STOPP_W-1:0]  cfg_stop     = STOPP_W'(1);
    bit                  genome_shadow [MAX_LENGTH];
    bit                  base_known    [MAX_LENGTH];

    t_scan_result        pending_scans [$];   // oldest query first
    bit                  calm_stretch  = 1'b0;
    int                  mismatch_count;
    int                  scans_checked;
    int                  requests_done;
    int                  queries_sent;
    int                  flips_sent;
    int                  reg_writes;
    int                  cycle_count;
    t_scan_result        got_scan;
    t_scan_result        want_scan;

    // length register is clamped into [MIN_LENGTH, MAX_LENGTH]
    function automatic int unsigned effective_length();
        int unsigned n;
        n = cfg_length;
        if (n < MIN_LENGTH) n = MIN_LENGTH;
        if (n > MAX_LENGTH) n = MAX_LENGTH;
        return n;
    endfunction

    function automatic logic genome_base(input int unsigned home, input int unsigned off);
        return genome_shadow[(home + off) % effective_length()];
    endfunction

    // motif rules for a query at store address home
    function automatic t_scan_result scan_genome(input int unsigned home);
        t_scan_result r;
        int unsigned  mism;
        int unsigned  i;
        int unsigned  k;
        r    = '0;
        mism = 0;
        for (i = 0; i < PROMOTER_SIZE; i++)
            mism += genome_base(home, i) ^ cfg_promoter[i];
        if (mism > cfg_max_diff + 1) mism = cfg_max_diff + 1;
        r.prom_dist = DIST_W'(mism);

        // stem holds only if every mirrored pair differs
        r.stem = STEM_W'(TERM_STEM);
        for (i = 0; i < TERM_STEM; i++)
            if (genome_base(home, i) == genome_base(home, TERM_SPAN - 1 - i)) r.stem = '0;

        // core bases then start codon past the spacer
        r.shine = 1'b1;
        for (i = 0; i < SD_CORE + CODON_BITS; i++) begin
            k = (i >= SD_CORE) ? i + SD_SPACER : i;
            if (genome_base(home, k) != cfg_shine[k]) r.shine = 1'b0;
        end

        r.stop = 1'b1;
        for (i = 0; i < CODON_BITS; i++)
            if (genome_base(home, i) != cfg_stop[i]) r.stop = 1'b0;

        // first base ends up in the MSB
        for (i = 0; i < CODON_BITS; i++)
            r.codon = {r.codon[CODON_W-2:0], genome_base(home, i)};
        return r;
    endfunction

    // apply an accepted request to the shadow; a query yields a result
    function automatic bit commit_request(input logic [CMD_W-1:0] cmd,
                                          input logic [ADDR_W-1:0] pos,
                                          input logic bv,
                                          output t_scan_result res);
        int unsigned addr;
        addr = pos % effective_length();
        res  = '0;
        case (cmd)
            CMD_WRITE: begin
                genome_shadow[addr] = bv;
                base_known[addr]    = 1'b1;
            end
            CMD_FLIP: begin
                genome_shadow[addr] = ~genome_shadow[addr];
            end
            CMD_QUERY: begin
                res = scan_genome(addr);
                return 1'b1;
            end
            default: ;  // spare code: no effect
        endcase
        return 1'b0;
    endfunction

    function automatic void commit_register(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] val);
        case (idx)
            CFG_LENGTH:   cfg_length   = val[LEN_W-1:0];
            CFG_PROMOTER: cfg_promoter = val[PROM_W-1:0];
            CFG_MAX_DIFF: cfg_max_diff = val[DIFF_W-1:0];
            CFG_SHINE:    cfg_shine    = val[SHINE_W-1:0];
            CFG_STOP:     cfg_stop     = val[STOPP_W-1:0];
            default: ;
        endcase
    endfunction

    // same store address, seen through a random multiple of the length
    function automatic logic [ADDR_W-1:0] alias_of(input int unsigned addr);
        int unsigned len;
        int unsigned hi;
        len = effective_length();
        hi  = (MAX_LENGTH - 1 - addr) / len;
        return ADDR_W'(addr + $urandom_range(0, hi) * len);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic compare_scan(input t_scan_result got, input t_scan_result want);
        if (got.prom_dist != want.prom_dist)
            report_mismatch($sformatf("result %0d promoter_distance got %0d want %0d",
                                      scans_checked, got.prom_dist, want.prom_dist));
        if (got.stem != want.stem)
            report_mismatch($sformatf("result %0d terminator_stem got %0d want %0d",
                                      scans_checked, got.stem, want.stem));
        if (got.shine != want.shine)
            report_mismatch($sformatf("result %0d shine_start got %0d want %0d",
                                      scans_checked, got.shine, want.shine));
        if (got.stop != want.stop)
            report_mismatch($sformatf("result %0d stop_found got %0d want %0d",
                                      scans_checked, got.stop, want.stop));
        if (got.codon != want.codon)
            report_mismatch($sformatf("result %0d codon_value got %0d want %0d",
                                      scans_checked, got.codon, want.codon));
        if (got.pad != want.pad)
            report_mismatch($sformatf("result %0d upper tdata bits got %0h, not zero",
                                      scans_checked, got.pad));
    endtask

    // Result side: compare on each accepted result, then pick next tready.
    // Also hosts the watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_scans.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_scan = t_scan_result'(m_axis_tdata);
                if (pending_scans.size() == 0) begin
                    report_mismatch($sformatf("result %0h with no query pending",
                                              m_axis_tdata));
                end else begin
                    want_scan = pending_scans.pop_front();
                    compare_scan(got_scan, want_scan);
                end
                scans_checked++;
            end
            m_axis_tready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Raise tvalid (after random idle cycles) and hold until accepted.
    // tvalid is left high on return; the next request or stream_idle()
    // decides its value in the acceptance step.
    task automatic push_request(input logic [CMD_W-1:0] cmd,
                                input logic [ADDR_W-1:0] pos,
                                input logic bv,
                                input bit typed,
                                input t_scan_result want);
        t_scan_result pred;
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, bv, pos, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        if (commit_request(cmd, pos, bv, pred))
            pending_scans.push_back(typed ? want : pred);
        if (cmd != CMD_SPARE) requests_done++;
        if (cmd == CMD_QUERY) queries_sent++;
        if (cmd == CMD_FLIP) flips_sent++;
    endtask

    // write every still-unwritten base a request at home would read
    task automatic ensure_known(input int unsigned home, input int unsigned span,
                                input bit rnd_fill);
        int unsigned off;
        int unsigned a;
        for (off = 0; off < span; off++) begin
            a = (home + off) % effective_length();
            if (!base_known[a])
                push_request(CMD_WRITE, ADDR_W'(a), rnd_fill ? 1'($urandom) : 1'b0,
                             1'b0, '0);
        end
    endtask

    // flips and queries only ever touch written bases
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] pos,
                         input logic bv, input bit rnd_fill,
                         input bit typed, input t_scan_result want);
        int unsigned home;
        home = pos % effective_length();
        if (cmd == CMD_FLIP) ensure_known(home, 1, rnd_fill);
        if (cmd == CMD_QUERY) ensure_known(home, WINDOW, rnd_fill);
        push_request(cmd, pos, bv, typed, want);
    endtask

    task automatic stream_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every result, then for any write or flip still in flight
    task automatic drain_scans();
        stream_idle();
        while (pending_scans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // back-to-back register writes; the enable drops after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                             input bit last);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        commit_register(idx, val);
        reg_writes++;
        if (last) begin
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    function automatic t_plan_row row_req(input logic [CMD_W-1:0] cmd,
                                          input int unsigned pos, input logic bv);
        t_plan_row r;
        r       = '{kind: ROW_REQUEST, default: '0};
        r.cmd   = cmd;
        r.pos   = ADDR_W'(pos);
        r.bv    = bv;
        return r;
    endfunction

    function automatic t_plan_row row_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input int unsigned val);
        t_plan_row r;
        r      = '{kind: ROW_REGISTER, default: '0};
        r.idx  = idx;
        r.val  = CFG_W'(val);
        return r;
    endfunction

    // query row; typed rows carry the result worked out by hand
    function automatic t_plan_row row_scan(input int unsigned pos, input bit typed,
                                           input int unsigned pdist, input int unsigned stem,
                                           input bit shine, input bit stop,
                                           input int unsigned codon);
        t_plan_row r;
        r                = row_req(CMD_QUERY, pos, 1'b0);
        r.typed          = typed;
        r.want.prom_dist = DIST_W'(pdist);
        r.want.stem      = STEM_W'(stem);
        r.want.shine     = shine;
        r.want.stop      = stop;
        r.want.codon     = CODON_W'(codon);
        return r;
    endfunction

    t_plan_row directed_plan [$];

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    // one register setting per phase; extremes in the fixed phases
    task automatic set_phase(input int ph);
        int unsigned len;
        int unsigned prom;
        int unsigned md;
        int unsigned sh;
        int unsigned st;
        len  = $urandom_range(32, MAX_LENGTH);
        prom = $urandom_range(0, (1 << PROM_W) - 1);
        md   = $urandom_range(0, (1 << DIFF_W) - 1);
        sh   = $urandom_range(0, (1 << SHINE_W) - 1);
        st   = $urandom_range(0, (1 << STOPP_W) - 1);
        case (ph)
            0: begin
                len = MIN_LENGTH;
                md  = 4;
                st  = 7;
            end
            1: begin
                len  = 0;  // below the floor, runs as the minimum
                prom = (1 << PROM_W) - 1;
                md   = PROMOTER_SIZE;
                sh   = (1 << SHINE_W) - 1;
                st   = 0;
            end
            2: len = $urandom_range(MIN_LENGTH + 1, 64);
            3: len = MAX_LENGTH;
            4: begin
                len = (1 << LEN_W) - 1;  // above the ceiling
                md  = 0;
                sh  = 0;
            end
            5: begin
                len = MIN_LENGTH - 1;
                md  = (1 << DIFF_W) - 1;
            end
            6: len = $urandom_range(65, 300);
            default: ;
        endcase
        write_reg(CFG_LENGTH, CFG_W'(len), 1'b0);
        write_reg(CFG_PROMOTER, CFG_W'(prom), 1'b0);
        write_reg(CFG_MAX_DIFF, CFG_W'(md), 1'b0);
        write_reg(CFG_SHINE, CFG_W'(sh), 1'b0);
        write_reg(CFG_STOP, CFG_W'(st), 1'b1);
    endtask

    // Write a window shaped like one of the motifs (or random), touch it
    // with a few flips, then query at and just past its start. A partial
    // run writes only the head of the window; the rest keeps older bases.
    task automatic run_motif(input bit partial);
        int unsigned       len;
        int unsigned       home;
        int unsigned       nwrite;
        int unsigned       off;
        int unsigned       j;
        logic [WINDOW-1:0] win;
        len  = effective_length();
        home = $urandom_range(0, MAX_LENGTH - 1) % len;
        win  = WINDOW'($urandom);
        case ($urandom_range(0, 4))
            1: begin
                // near the promoter: a handful of mismatches around the cap
                win = cfg_promoter;
                repeat ($urandom_range(0, 6)) begin
                    j      = $urandom_range(0, WINDOW - 1);
                    win[j] = ~win[j];
                end
            end
            2: begin
                // core and start codon from the pattern, spacer left random
                win[SD_CORE-1:0] = cfg_shine[SD_CORE-1:0];
                win[SD_CORE+SD_SPACER+CODON_BITS-1:SD_CORE+SD_SPACER] =
                    cfg_shine[SD_CORE+SD_SPACER+CODON_BITS-1:SD_CORE+SD_SPACER];
                if ($urandom_range(0, 3) == 0) begin
                    j      = $urandom_range(0, SD_CORE + SD_SPACER + CODON_BITS - 1);
                    win[j] = ~win[j];
                end
            end
            3: win[CODON_BITS-1:0] = cfg_stop;
            4: begin
                // hairpin: mirrored pairs differ, sometimes one pair spoiled
                for (j = 0; j < TERM_STEM; j++) win[TERM_SPAN-1-j] = ~win[j];
                if ($urandom_range(0, 3) == 0) begin
                    j                  = $urandom_range(0, TERM_STEM - 1);
                    win[TERM_SPAN-1-j] = win[j];
                end
            end
            default: ;
        endcase
        nwrite = partial ? $urandom_range(0, WINDOW - 1) : WINDOW;
        for (off = 0; off < nwrite; off++)
            issue(CMD_WRITE, alias_of((home + off) % len), win[off], 1'b1, 1'b0, '0);
        repeat ($urandom_range(0, 2))
            issue(CMD_FLIP, alias_of((home + $urandom_range(0, WINDOW - 1)) % len),
                  1'($urandom), 1'b1, 1'b0, '0);
        repeat ($urandom_range(1, 3))
            issue(CMD_QUERY, alias_of((home + $urandom_range(0, 2)) % len),
                  1'($urandom), 1'b1, 1'b0, '0);
    endtask

    // unshaped requests, spare code included, any raw position
    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            issue(CMD_W'($urandom), ADDR_W'($urandom), 1'($urandom), 1'b1, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int ph;
        int target;
        int pick;
        int r;

        // Directed rows. The store reads as zero here: every base a row
        // touches is first written with 0. Registers start at reset values.
        directed_plan.push_back(row_scan(0, 1'b1, 0, 0, 1'b1, 1'b0, 0));       // after reset
        directed_plan.push_back(row_scan(MAX_LENGTH - 1, 1'b1, 0, 0, 1'b1, 1'b0, 0));
        directed_plan.push_back(row_req(CMD_SPARE, 5, 1'b1));                   // ignored
        directed_plan.push_back(row_req(CMD_WRITE, 0, 1'b1));
        directed_plan.push_back(row_scan(0, 1'b1, 1, 0, 1'b0, 1'b1, 4));
        // window wraps past the top of the store
        directed_plan.push_back(row_scan(MAX_LENGTH - 1, 1'b1, 1, 0, 1'b0, 1'b0, 2));
        directed_plan.push_back(row_req(CMD_FLIP, 0, 1'b0));
        directed_plan.push_back(row_scan(0, 1'b1, 0, 0, 1'b1, 1'b0, 0));
        directed_plan.push_back(row_req(CMD_FLIP, MAX_LENGTH - 1, 1'b1));
        directed_plan.push_back(row_scan(MAX_LENGTH - 2, 1'b0, 0, 0, 1'b0, 1'b0, 0));
        // promoter all ones against zeros: distance is the full width
        directed_plan.push_back(row_reg(CFG_PROMOTER, (1 << PROM_W) - 1));
        directed_plan.push_back(row_reg(CFG_MAX_DIFF, PROMOTER_SIZE));
        directed_plan.push_back(row_scan(100, 1'b1, 22, 0, 1'b1, 1'b0, 0));
        // cap of zero mismatches saturates at one
        directed_plan.push_back(row_reg(CFG_MAX_DIFF, 0));
        directed_plan.push_back(row_scan(100, 1'b1, 1, 0, 1'b1, 1'b0, 0));
        directed_plan.push_back(row_reg(CFG_MAX_DIFF, (1 << DIFF_W) - 1));
        // full stem: ones on the left arm, zeros on the right
        for (r = 200; r < 200 + TERM_STEM; r++)
            directed_plan.push_back(row_req(CMD_WRITE, r, 1'b1));
        directed_plan.push_back(row_scan(200, 1'b1, 18, 4, 1'b0, 1'b0, 7));
        // length below the floor and beyond the store
        directed_plan.push_back(row_reg(CFG_LENGTH, 0));
        directed_plan.push_back(row_scan(MAX_LENGTH - 1, 1'b0, 0, 0, 1'b0, 1'b0, 0));
        directed_plan.push_back(row_reg(CFG_LENGTH, (1 << LEN_W) - 1));
        directed_plan.push_back(row_scan(MAX_LENGTH - 1, 1'b0, 0, 0, 1'b0, 1'b0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_REGISTER) begin
                drain_scans();
                write_reg(directed_plan[i].idx, directed_plan[i].val, 1'b1);
            end else begin
                issue(directed_plan[i].cmd, directed_plan[i].pos, directed_plan[i].bv,
                      1'b0, directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // random phases, each under its own register setting
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_scans();
            set_phase(ph);
            calm_stretch = (ph == CALM_PHASE);
            target       = requests_done + PHASE_REQUESTS;
            while (requests_done < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) run_motif(1'b0);
                else if (pick < 82) run_motif(1'b1);
                else run_noise();
                // now and then hold the request side until all results are in
                if ($urandom_range(0, 39) == 0) drain_scans();
            end
        end
        calm_stretch = 1'b0;

        drain_scans();
        $display("covered %0d requests: %0d queries, %0d flips, the rest writes",
                 requests_done, queries_sent, flips_sent);
        $display("%0d register writes over %0d settings, %0d results compared, %0d mismatches",
                 reg_writes, N_PHASES + 1, scans_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
